>>> rtl/core/bpra_pkg.sv
package bpra_pkg;

    // Map geometry
    localparam int MAX_PAGES = 1024;
    localparam int MAX_RUN   = 32;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;

    // Field and index widths
    localparam int PAGE_W  = $clog2(MAX_PAGES);
    localparam int WIDX_W  = $clog2(MAP_WORDS);
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int CNT_W   = 6;
    localparam int CFG_W   = 11;
    localparam int LEN_W   = CFG_W;
    localparam int CARRY_W = $clog2(MAX_RUN + 1);
    localparam int EXT_W   = WORD_BITS + MAX_RUN;

    // Request kinds
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Result codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NO_RUN = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FOUND,
        S_TOG_RD,
        S_TOG_WA,
        S_TOG_WB,
        S_FINISH
    } state_t;

    // Outcome of scanning one map word
    typedef struct packed {
        logic               hit;
        logic [BIT_W-1:0]   hit_bit;
        logic [CARRY_W-1:0] carry_out;
    } scan_res_t;

endpackage

>>> rtl/core/bpra_map_mem.sv
module bpra_map_mem (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 rd_en,
    input  logic [bpra_pkg::WIDX_W-1:0]          rd_addr,
    output logic [bpra_pkg::WORD_BITS-1:0]       rd_data,
    input  logic                                 wr_en,
    input  logic [bpra_pkg::WIDX_W-1:0]          wr_addr,
    input  logic [bpra_pkg::WORD_BITS-1:0]       wr_data
);

    logic [bpra_pkg::WORD_BITS-1:0] mem [bpra_pkg::MAP_WORDS];
    logic [bpra_pkg::MAP_WORDS-1:0] valid_reg;
    logic [bpra_pkg::WORD_BITS-1:0] rd_data_reg;
    logic                           rd_vld_reg;

    // Word storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Per-word valid bits: an unwritten word reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

>>> rtl/core/bpra_word_scan.sv
module bpra_word_scan (
    input  logic [bpra_pkg::WORD_BITS-1:0] word,
    input  logic [bpra_pkg::WIDX_W-1:0]    word_idx,
    input  logic [bpra_pkg::LEN_W-1:0]     len,
    input  logic [bpra_pkg::CNT_W-1:0]     count,
    input  logic [bpra_pkg::CARRY_W-1:0]   carry_in,
    output bpra_pkg::scan_res_t            res
);

    localparam int REM_W = bpra_pkg::LEN_W + 2;
    localparam int SH_N  = bpra_pkg::CNT_W;

    logic signed [REM_W-1:0]          rem;
    logic [bpra_pkg::WORD_BITS-1:0]   valid_mask;
    logic [bpra_pkg::WORD_BITS-1:0]   free_bits;
    logic [bpra_pkg::EXT_W-1:0]       ext;
    logic [bpra_pkg::EXT_W-1:0]       pw [SH_N];
    logic [bpra_pkg::EXT_W-1:0]       pm;
    logic [bpra_pkg::CNT_W-1:0]       shift_amt;
    logic [bpra_pkg::EXT_W-1:0]       win;

    // Pages at or beyond the managed length count as used
    always_comb
    begin
        rem = $signed({2'b00, len})
            - $signed(REM_W'({word_idx, {bpra_pkg::BIT_W{1'b0}}}));
        if (rem >= REM_W'(bpra_pkg::WORD_BITS))
        begin
            valid_mask = '1;
        end
        else if (rem <= 0)
        begin
            valid_mask = '0;
        end
        else
        begin
            valid_mask = ({{(bpra_pkg::WORD_BITS-1){1'b0}}, 1'b1} << rem[bpra_pkg::BIT_W-1:0])
                       - {{(bpra_pkg::WORD_BITS-1){1'b0}}, 1'b1};
        end
        free_bits = ~word & valid_mask;
    end

    // Extended free vector: free pages carried in from earlier words sit below bit 0
    always_comb
    begin
        for (int j = 0; j < bpra_pkg::MAX_RUN; j++)
        begin
            ext[j] = ({1'b0, carry_in} + (bpra_pkg::CARRY_W+1)'(j))
                     >= (bpra_pkg::CARRY_W+1)'(bpra_pkg::MAX_RUN);
        end
        ext[bpra_pkg::EXT_W-1:bpra_pkg::MAX_RUN] = free_bits;
    end

    // Free windows of length 2^k ending at each position
    always_comb
    begin
        pw[0] = ext;
        for (int k = 0; k < SH_N - 1; k++)
        begin
            pw[k+1] = pw[k] & (pw[k] << (1 << k));
        end
    end

    // Window of length count = two overlapping power-of-two windows
    always_comb
    begin
        priority if (count[5])
        begin
            pm        = pw[5];
            shift_amt = count - 6'd32;
        end
        else if (count[4])
        begin
            pm        = pw[4];
            shift_amt = count - 6'd16;
        end
        else if (count[3])
        begin
            pm        = pw[3];
            shift_amt = count - 6'd8;
        end
        else if (count[2])
        begin
            pm        = pw[2];
            shift_amt = count - 6'd4;
        end
        else if (count[1])
        begin
            pm        = pw[1];
            shift_amt = count - 6'd2;
        end
        else
        begin
            pm        = pw[0];
            shift_amt = '0;
        end
        win = pm & (pm << shift_amt);
    end

    // Lowest run end in this word, and free pages running out of its top
    always_comb
    begin
        res.hit       = 1'b0;
        res.hit_bit   = '0;
        res.carry_out = bpra_pkg::CARRY_W'(bpra_pkg::MAX_RUN);
        for (int b = bpra_pkg::WORD_BITS - 1; b >= 0; b--)
        begin
            if (win[bpra_pkg::MAX_RUN + b])
            begin
                res.hit     = 1'b1;
                res.hit_bit = bpra_pkg::BIT_W'(b);
            end
        end
        for (int i = bpra_pkg::WORD_BITS - bpra_pkg::MAX_RUN; i < bpra_pkg::WORD_BITS; i++)
        begin
            if (!free_bits[i])
            begin
                res.carry_out = bpra_pkg::CARRY_W'(bpra_pkg::WORD_BITS - 1 - i);
            end
        end
    end

endmodule

>>> rtl/core/bitmap_page_run_allocator_top.sv
// First-fit page-run allocator over a 1024-page bitmap (one bit per page).
// Request channel (in_valid/in_ready): action, first_page, page_count.
// Allocate looks for the lowest run of page_count free pages below the
// managed page count; release toggles the given run. Result channel
// (out_valid/out_ready): status and start_page, one result per request.
// cfg_we/cfg_wdata set the managed page count; write it only while idle.
// The map is held in a 16 x 64-bit memory with a registered read. A
// malformed request goes straight to its result; an allocate first scans
// up from word 0 (all 16 words when it finds no run). A found run or a
// release reads and rewrites its word, and the next one if it crosses.
// in_ready rises in the cycle after the result is loaded.
// One request is in flight at a time; in_ready is high only when idle.
// The result sits in an output register; a stalled receiver holds the
// finished request until out_ready, and the next request waits meanwhile.
// Reset marks every page free (per-word valid bits, no clearing pass) and
// sets the managed page count to 1024.
module bitmap_page_run_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [bpra_pkg::PAGE_W-1:0]   first_page,
    input  logic [bpra_pkg::CNT_W-1:0]    page_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [bpra_pkg::PAGE_W-1:0]   start_page,
    input  logic                          cfg_we,
    input  logic [bpra_pkg::CFG_W-1:0]    cfg_wdata
);

    bpra_pkg::state_t               state_reg, state_next;
    logic                           action_reg, action_next;
    logic [bpra_pkg::PAGE_W-1:0]    first_reg, first_next;
    logic [bpra_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [bpra_pkg::WIDX_W-1:0]    scan_w_reg, scan_w_next;
    logic [bpra_pkg::CARRY_W-1:0]   carry_reg, carry_next;
    logic [bpra_pkg::BIT_W-1:0]     hit_bit_reg, hit_bit_next;
    logic [bpra_pkg::PAGE_W-1:0]    start_reg, start_next;
    logic [1:0]                     res_status_reg, res_status_next;
    logic                           out_valid_reg, out_valid_next;
    logic [1:0]                     out_status_reg, out_status_next;
    logic [bpra_pkg::PAGE_W-1:0]    out_start_reg, out_start_next;
    logic [bpra_pkg::CFG_W-1:0]     pages_in_use_reg;

    logic [bpra_pkg::LEN_W-1:0]     len;
    logic                           mem_rd_en;
    logic [bpra_pkg::WIDX_W-1:0]    mem_rd_addr;
    logic [bpra_pkg::WORD_BITS-1:0] mem_rd_data;
    logic                           mem_wr_en;
    logic [bpra_pkg::WIDX_W-1:0]    mem_wr_addr;
    logic [bpra_pkg::WORD_BITS-1:0] mem_wr_data;
    logic [bpra_pkg::EXT_W-1:0]     run_ones;
    logic [bpra_pkg::EXT_W-1:0]     tog_mask;
    logic [bpra_pkg::WIDX_W-1:0]    tog_word;
    logic [bpra_pkg::LEN_W-1:0]     rel_end;
    logic [bpra_pkg::LEN_W-1:0]     found_start;
    logic                           out_load;
    bpra_pkg::scan_res_t            scan_res;

    // Page count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_in_use_reg <= bpra_pkg::CFG_W'(bpra_pkg::MAX_PAGES);
        end
        else if (cfg_we)
        begin
            pages_in_use_reg <= cfg_wdata;
        end
    end

    assign len = (pages_in_use_reg > bpra_pkg::CFG_W'(bpra_pkg::MAX_PAGES))
               ? bpra_pkg::LEN_W'(bpra_pkg::MAX_PAGES) : pages_in_use_reg;

    // Free map storage
    bpra_map_mem u_map_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // Run search on the word just read
    bpra_word_scan u_word_scan (
        .word     (mem_rd_data),
        .word_idx (scan_w_reg),
        .len      (len),
        .count    (count_reg),
        .carry_in (carry_reg),
        .res      (scan_res)
    );

    // Toggle mask of the run, spanning at most two words
    always_comb
    begin
        run_ones    = ({{(bpra_pkg::EXT_W-1){1'b0}}, 1'b1} << count_reg)
                    - {{(bpra_pkg::EXT_W-1){1'b0}}, 1'b1};
        tog_mask    = run_ones << start_reg[bpra_pkg::BIT_W-1:0];
        tog_word    = start_reg[bpra_pkg::PAGE_W-1:bpra_pkg::BIT_W];
        rel_end     = bpra_pkg::LEN_W'(first_reg) + bpra_pkg::LEN_W'(count_reg);
        found_start = bpra_pkg::LEN_W'({scan_w_reg, hit_bit_reg}) + 1'b1
                    - bpra_pkg::LEN_W'(count_reg);
    end

    // Sequencer: decode, word scan, read-modify-write of the run, result
    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        first_next      = first_reg;
        count_next      = count_reg;
        scan_w_next     = scan_w_reg;
        carry_next      = carry_reg;
        hit_bit_next    = hit_bit_reg;
        start_next      = start_reg;
        res_status_next = res_status_reg;
        in_ready        = 1'b0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = '0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = tog_word;
        mem_wr_data     = mem_rd_data ^ tog_mask[bpra_pkg::WORD_BITS-1:0];
        out_load        = 1'b0;

        unique case (state_reg)
            bpra_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    action_next = action;
                    first_next  = first_page;
                    count_next  = page_count;
                    state_next  = bpra_pkg::S_DECODE;
                end
            end
            bpra_pkg::S_DECODE:
            begin
                if (count_reg == '0 || count_reg > bpra_pkg::CNT_W'(bpra_pkg::MAX_RUN))
                begin
                    res_status_next = bpra_pkg::ST_BAD;
                    state_next      = bpra_pkg::S_FINISH;
                end
                else if (action_reg == bpra_pkg::ACT_ALLOC)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = '0;
                    scan_w_next = '0;
                    carry_next  = '0;
                    state_next  = bpra_pkg::S_SCAN;
                end
                else if (rel_end > len)
                begin
                    res_status_next = bpra_pkg::ST_BAD;
                    state_next      = bpra_pkg::S_FINISH;
                end
                else
                begin
                    start_next      = first_reg;
                    res_status_next = bpra_pkg::ST_DONE;
                    state_next      = bpra_pkg::S_TOG_RD;
                end
            end
            bpra_pkg::S_SCAN:
            begin
                if (scan_res.hit)
                begin
                    hit_bit_next = scan_res.hit_bit;
                    state_next   = bpra_pkg::S_FOUND;
                end
                else if (scan_w_reg == bpra_pkg::WIDX_W'(bpra_pkg::MAP_WORDS - 1))
                begin
                    res_status_next = bpra_pkg::ST_NO_RUN;
                    state_next      = bpra_pkg::S_FINISH;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = scan_w_reg + 1'b1;
                    scan_w_next = scan_w_reg + 1'b1;
                    carry_next  = scan_res.carry_out;
                end
            end
            bpra_pkg::S_FOUND:
            begin
                start_next      = found_start[bpra_pkg::PAGE_W-1:0];
                res_status_next = bpra_pkg::ST_DONE;
                state_next      = bpra_pkg::S_TOG_RD;
            end
            bpra_pkg::S_TOG_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = tog_word;
                state_next  = bpra_pkg::S_TOG_WA;
            end
            bpra_pkg::S_TOG_WA:
            begin
                // Reads and writes here never hit the same word
                mem_wr_en = 1'b1;
                if (|tog_mask[bpra_pkg::EXT_W-1:bpra_pkg::WORD_BITS])
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = tog_word + 1'b1;
                    state_next  = bpra_pkg::S_TOG_WB;
                end
                else
                begin
                    state_next = bpra_pkg::S_FINISH;
                end
            end
            bpra_pkg::S_TOG_WB:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = tog_word + 1'b1;
                mem_wr_data = mem_rd_data
                            ^ bpra_pkg::WORD_BITS'(tog_mask[bpra_pkg::EXT_W-1:bpra_pkg::WORD_BITS]);
                state_next  = bpra_pkg::S_FINISH;
            end
            bpra_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = bpra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bpra_pkg::S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_start_next  = (res_status_reg == bpra_pkg::ST_DONE
                               && action_reg == bpra_pkg::ACT_ALLOC) ? start_reg : '0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpra_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        first_reg      <= first_next;
        count_reg      <= count_next;
        scan_w_reg     <= scan_w_next;
        carry_reg      <= carry_next;
        hit_bit_reg    <= hit_bit_next;
        start_reg      <= start_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign start_page = out_start_reg;

    // Scan runs only for well-formed allocate requests
    a_scan_alloc_only: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bpra_pkg::S_SCAN |-> action_reg == bpra_pkg::ACT_ALLOC
            && count_reg != '0 && count_reg <= bpra_pkg::CNT_W'(bpra_pkg::MAX_RUN))
        else $error("scan entered for a malformed or release request");

    // A run never spills past the last map word
    a_no_spill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bpra_pkg::S_TOG_WB
            |-> tog_word != bpra_pkg::WIDX_W'(bpra_pkg::MAP_WORDS - 1))
        else $error("run crosses the end of the map");

    // A completed run lies inside the managed pages
    a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bpra_pkg::S_FINISH && res_status_reg == bpra_pkg::ST_DONE
            |-> bpra_pkg::LEN_W'(start_reg) + bpra_pkg::LEN_W'(count_reg) <= len)
        else $error("completed run outside managed pages");

    // A result appears only on leaving the finish state
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == bpra_pkg::S_FINISH)
        else $error("result raised outside finish state");

endmodule

>>> tb/sv/page_run_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and page-count ports of the allocator, keeps
// its own copy of the page map and checks every result in order.
module page_run_checker
    import bpra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              action,
    input  logic [PAGE_W-1:0] first_page,
    input  logic [CNT_W-1:0]  page_count,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [1:0]        status,
    input  logic [PAGE_W-1:0] start_page,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    output int                fail_count,
    output int                pending,
    output int                checked,
    output int                grants,
    output int                no_runs,
    output int                rejects
);

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] start;
    } page_result_t;

    // One bit per page, set while the page is in use
    logic [MAX_PAGES-1:0] page_busy;
    logic [CFG_W-1:0]     page_span_cfg;
    page_result_t         awaited_results[$];

    // First-fit search or toggle of a run; updates the page map
    function automatic page_result_t serve_page_request(
        input logic              act,
        input logic [PAGE_W-1:0] first,
        input logic [CNT_W-1:0]  count
    );
        page_result_t res;
        int           span;
        int           run_len;
        logic         found;

        res.status = ST_DONE;
        res.start  = '0;
        span = (page_span_cfg > MAX_PAGES) ? MAX_PAGES : int'(page_span_cfg);
        if (count == 0 || count > MAX_RUN) begin
            res.status = ST_BAD;
        end
        else if (act == ACT_ALLOC) begin
            res.status = ST_NO_RUN;
            run_len = 0;
            found = 1'b0;
            for (int p = 0; p < span && !found; p++)
            begin
                if (page_busy[p])
                    run_len = 0;
                else
                    run_len++;
                if (run_len == int'(count))
                begin
                    found = 1'b1;
                    for (int q = p - int'(count) + 1; q <= p; q++)
                        page_busy[q] = 1'b1;
                    res.status = ST_DONE;
                    res.start  = PAGE_W'(p - int'(count) + 1);
                end
            end
        end
        else if (int'(first) + int'(count) > span) begin
            res.status = ST_BAD;
        end
        else begin
            for (int q = int'(first); q < int'(first) + int'(count); q++)
                page_busy[q] = ~page_busy[q];
        end
        return res;
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
        grants     = 0;
        no_runs    = 0;
        rejects    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        page_result_t want;
        if (!rst_n)
        begin
            page_busy     = '0;
            page_span_cfg = CFG_W'(MAX_PAGES);
            awaited_results.delete();
            pending = 0;
        end
        else
        begin
            // result accepted: compare with the oldest awaited one
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got status %0d start %0d",
                             $time, status, start_page);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    checked++;
                    if (status !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, status);
                    end
                    if (start_page !== want.start)
                    begin
                        fail_count++;
                        $display("%0t: start_page mismatch, expected %0d, got %0d",
                                 $time, want.start, start_page);
                    end
                end
            end

            // request accepted: predict its result
            if (in_valid && in_ready)
            begin
                want = serve_page_request(action, first_page, page_count);
                awaited_results.push_back(want);
                case (want.status)
                    ST_DONE:   if (action == ACT_ALLOC) grants++;
                    ST_NO_RUN: no_runs++;
                    default:   rejects++;
                endcase
            end

            if (cfg_we)
                page_span_cfg = cfg_wdata;
            pending = awaited_results.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import bpra_pkg::*;

    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int BLOCK_ITEMS  = 72;
    localparam int BLOCKS       = 6;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              action;
    logic [PAGE_W-1:0] first_page;
    logic [CNT_W-1:0]  page_count;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        status;
    logic [PAGE_W-1:0] start_page;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;

    int fail_count;
    int pending;
    int checked;
    int grants;
    int no_runs;
    int rejects;

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_req_cnt;
    int hold_seen;
    int cycle_count = 0;
    int managed;

    logic [CFG_W-1:0] span_list [BLOCKS];

    bitmap_page_run_allocator_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .first_page (first_page),
        .page_count (page_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .start_page (start_page),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    page_run_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .first_page (first_page),
        .page_count (page_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .start_page (start_page),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .grants     (grants),
        .no_runs    (no_runs),
        .rejects    (rejects)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off when asked for
    initial
    begin
        out_ready = 1'b0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req_cnt != hold_seen)
            begin
                hold_seen = hold_req_cnt;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offer one request and hold it until taken
    task automatic offer_request(
        input logic              act,
        input logic [PAGE_W-1:0] first,
        input logic [CNT_W-1:0]  count
    );
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        first_page <= first;
        page_count <= count;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Change the managed page count while the block is idle
    task automatic set_page_span(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        managed = (value > MAX_PAGES) ? MAX_PAGES : int'(value);
    endtask

    // Mostly well-formed allocate and release requests, some malformed
    task automatic offer_random_request();
        int pick;
        int count;
        int first;

        pick = $urandom_range(99);
        if (pick < 50)
        begin
            count = ($urandom_range(9) < 7) ? $urandom_range(8, 1)
                                             : $urandom_range(MAX_RUN, 1);
            offer_request(ACT_ALLOC, PAGE_W'($urandom), CNT_W'(count));
        end
        else if (pick < 88)
        begin
            count = ($urandom_range(1) == 0) ? $urandom_range(8, 1)
                                              : $urandom_range(MAX_RUN, 1);
            if (managed > count && $urandom_range(9) != 0)
                first = $urandom_range(managed - count);
            else
                first = $urandom_range(MAX_PAGES - 1);
            offer_request(ACT_RELEASE, PAGE_W'(first), CNT_W'(count));
        end
        else
        begin
            count = ($urandom_range(3) == 0) ? 0 : $urandom_range(63, MAX_RUN + 1);
            offer_request(logic'($urandom_range(1)), PAGE_W'($urandom), CNT_W'(count));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_ALLOC;
        first_page   = '0;
        page_count   = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        hold_req_cnt = 0;
        tx_idle_pct  = 7;
        rx_stall_pct = 53;
        managed      = MAX_PAGES;

        span_list[0] = CFG_W'(1024);
        span_list[1] = CFG_W'(96);
        span_list[2] = CFG_W'(2047);
        span_list[3] = CFG_W'(65);
        span_list[4] = CFG_W'($urandom_range(2047));
        span_list[5] = CFG_W'(33);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // malformed counts, both request kinds
        offer_request(ACT_ALLOC,   10'd1023, 6'd0);
        offer_request(ACT_ALLOC,   10'd0,    6'd33);
        offer_request(ACT_RELEASE, 10'd1023, 6'd63);
        offer_request(ACT_RELEASE, 10'd5,    6'd0);
        // fill from page 0, across the first word boundary
        offer_request(ACT_ALLOC,   10'd0,    6'd1);
        offer_request(ACT_ALLOC,   10'd1023, 6'd32);
        offer_request(ACT_ALLOC,   10'd0,    6'd31);
        offer_request(ACT_ALLOC,   10'd0,    6'd5);
        // free a hole and refill it
        offer_request(ACT_RELEASE, 10'd1,    6'd32);
        offer_request(ACT_ALLOC,   10'd0,    6'd32);
        offer_request(ACT_RELEASE, 10'd60,   6'd8);
        offer_request(ACT_ALLOC,   10'd0,    6'd6);
        // top of the map, out of range, toggling free pages
        offer_request(ACT_RELEASE, 10'd1000, 6'd24);
        offer_request(ACT_RELEASE, 10'd1001, 6'd24);
        offer_request(ACT_RELEASE, 10'd1023, 6'd1);
        offer_request(ACT_RELEASE, 10'd200,  6'd20);
        // empty map
        set_page_span(CFG_W'(0));
        offer_request(ACT_ALLOC,   10'd0,    6'd1);
        offer_request(ACT_RELEASE, 10'd0,    6'd1);
        // request larger than the map
        set_page_span(CFG_W'(20));
        offer_request(ACT_ALLOC,   10'd0,    6'd32);
        offer_request(ACT_ALLOC,   10'd0,    6'd20);
        // page count above the map size is clamped
        set_page_span(CFG_W'(2047));
        offer_request(ACT_ALLOC,   10'd0,    6'd32);
        offer_request(ACT_RELEASE, 10'd992,  6'd32);
        offer_request(ACT_RELEASE, 10'd993,  6'd32);

        // random blocks, each with its own page count; each pair of blocks has its own idling mix
        for (int b = 0; b < BLOCKS; b++)
        begin
            set_page_span(span_list[b]);
            if (b < 2)
            begin
                tx_idle_pct = 7;
                rx_stall_pct <= 53;
            end
            else if (b < 4)
            begin
                tx_idle_pct = 53;
                rx_stall_pct <= 7;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_stall_pct <= 0;
            end
            for (int i = 0; i < BLOCK_ITEMS; i++)
            begin
                // long result stall while requests keep coming
                if (b == 1 && i == 20)
                    hold_req_cnt <= hold_req_cnt + 1;
                // sender waits for everything outstanding
                if (b == 3 && i == 36)
                    drain_results();
                offer_random_request();
            end
        end

        drain_results();
        repeat (30) @(posedge clk);

        $display("Checked %0d results over %0d page-count settings", checked, BLOCKS + 4);
        $display("Runs granted %0d, no free run %0d, rejected %0d", grants, no_runs, rejects);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
